### sv/ilr_pkg.sv
package ilr_pkg;

	// field and register widths
	localparam int ADDR_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 3;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// defaults for the top-level parameters
	localparam int TABLE_ENTRIES_DEF = 4;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// commands
	localparam logic [CMD_W-1:0] CMD_OUTBOUND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INBOUND  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ASIS   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAILED = 2'd2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_IFACE_ADDRESS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IFACE_MASK    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_IFACE_UP      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAP_ENTRY_0   = 3'd4;

	// what the back end does with the queued data word
	typedef enum logic [1:0] {
		ACT_COPY,
		ACT_ADD,
		ACT_ZERO
	} act_t;

	// classified word passed from front to back
	typedef struct packed {
		act_t                act;
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   data;
	} item_t;

	// interface settings seen by front and back
	typedef struct packed {
		logic [ADDR_W-1:0]  iface_address;
		logic [ADDR_W-1:0]  iface_mask;
		logic               iface_up;
		logic [COUNT_W-1:0] entry_count;
	} cfg_t;

endpackage

### sv/ilr_front.sv
module ilr_front #(
	parameter int TABLE_ENTRIES = ilr_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ilr_pkg::CMD_W-1:0]  command,
	input  logic [ilr_pkg::ADDR_W-1:0] address,
	input  ilr_pkg::cfg_t              cfg,
	input  logic [ilr_pkg::ADDR_W-1:0] offset   [TABLE_ENTRIES],
	input  logic [ilr_pkg::ADDR_W-1:0] loopback [TABLE_ENTRIES],
	output logic                       valid_s1,
	output ilr_pkg::item_t             item_s1
);

	logic                          in_subnet;
	logic [ilr_pkg::ADDR_W-1:0]    host;
	logic [ilr_pkg::COUNT_W-1:0]   live;
	logic [TABLE_ENTRIES-1:0]      off_hit;
	logic [TABLE_ENTRIES-1:0]      loop_hit;
	logic [ilr_pkg::ADDR_W-1:0]    off_sel_loop;
	logic [ilr_pkg::ADDR_W-1:0]    loop_sel_off;
	logic                          out_match;
	ilr_pkg::item_t                item_d;

	// compare all live entries in parallel
	always_comb begin
		in_subnet = ((address ^ cfg.iface_address) & cfg.iface_mask) == '0;
		host      = address & ~cfg.iface_mask;
		if (cfg.entry_count > ilr_pkg::COUNT_W'(TABLE_ENTRIES))
			live = ilr_pkg::COUNT_W'(TABLE_ENTRIES);
		else
			live = cfg.entry_count;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			off_hit[k]  = (ilr_pkg::COUNT_W'(k) < live) && (offset[k] == host);
			loop_hit[k] = (ilr_pkg::COUNT_W'(k) < live) && (loopback[k] == address);
		end
	end

	// pick the lowest-numbered hit
	always_comb begin
		off_sel_loop = '0;
		loop_sel_off = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (off_hit[k])
				off_sel_loop = loopback[k];
			if (loop_hit[k])
				loop_sel_off = offset[k];
		end
		out_match = in_subnet && (|off_hit);
	end

	// classify the word by command
	always_comb begin
		item_d.act    = ilr_pkg::ACT_ZERO;
		item_d.status = ilr_pkg::ST_FAILED;
		item_d.data   = address;
		case (command)
			ilr_pkg::CMD_OUTBOUND: begin
				item_d.act = ilr_pkg::ACT_COPY;
				if (cfg.iface_up && out_match) begin
					item_d.status = ilr_pkg::ST_MAPPED;
					item_d.data   = off_sel_loop;
				end else begin
					item_d.status = ilr_pkg::ST_ASIS;
				end
			end
			ilr_pkg::CMD_INBOUND: begin
				if (address[31:24] != 8'd127) begin
					item_d.act    = ilr_pkg::ACT_COPY;
					item_d.status = ilr_pkg::ST_ASIS;
				end else if (|loop_hit) begin
					item_d.act    = ilr_pkg::ACT_ADD;
					item_d.status = ilr_pkg::ST_MAPPED;
					item_d.data   = loop_sel_off;
				end
			end
			ilr_pkg::CMD_CHECK: begin
				item_d.act    = ilr_pkg::ACT_COPY;
				item_d.status = out_match ? ilr_pkg::ST_MAPPED : ilr_pkg::ST_ASIS;
			end
			default: begin
				item_d.act    = ilr_pkg::ACT_ZERO;
				item_d.status = ilr_pkg::ST_FAILED;
			end
		endcase
	end

	// register the classified word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid)
			item_s1 <= item_d;
	end

endmodule

### sv/ilr_queue.sv
module ilr_queue #(
	parameter int DEPTH = ilr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  ilr_pkg::item_t               push_item,
	input  logic                         pop,
	output ilr_pkg::item_t               pop_item,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ilr_pkg::item_t    slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign do_pop   = pop && (count_q != '0);
	assign do_push  = push && ((count_q != CNT_W'(DEPTH)) || do_pop);
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign pop_item = slot_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// store the incoming word
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

### sv/ilr_back.sv
module ilr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  ilr_pkg::item_t                head,
	input  ilr_pkg::cfg_t                 cfg,
	output logic                          pop,
	output logic                          done,
	output logic [ilr_pkg::STATUS_W-1:0]  status,
	output logic [ilr_pkg::ADDR_W-1:0]    result_address
);

	logic [ilr_pkg::ADDR_W-1:0] base;
	logic [ilr_pkg::ADDR_W-1:0] res_d;
	logic                       done_q;
	logic [ilr_pkg::STATUS_W-1:0] status_q;
	logic [ilr_pkg::ADDR_W-1:0] result_q;

	// drain one word per cycle while the queue is not empty; the receiver never stalls
	assign pop  = !empty;
	assign base = cfg.iface_address & cfg.iface_mask;

	// form the result address, wrapping the sum at 32 bits
	always_comb begin
		case (head.act)
			ilr_pkg::ACT_COPY: res_d = head.data;
			ilr_pkg::ACT_ADD:  res_d = base + head.data;
			ilr_pkg::ACT_ZERO: res_d = '0;
			default:           res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= head.status;
			result_q <= res_d;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = result_q;

endmodule

### sv/ipv4_loopback_remap_core.sv
// IPv4 loopback remapper.
// Issue a word by raising start with command and address while busy is low;
// the word is taken at that clock edge. Commands: outbound remap (subnet host
// to loopback), inbound remap (loopback to subnet base plus offset) and check
// (report a match only). Each word gives exactly one result on status and
// result_address, marked by done for a single cycle, in issue order.
// A word passes the front end register, the word queue and then the back end
// output register, which raises done with status and result_address.
// Throughput: one word per cycle while busy is low; all table entries are compared at once.
// busy rises when the queued words plus the word in the front end reach the
// queue depth; with the default depth this does not happen in steady use,
// since the back end drains every cycle and the receiver cannot stall.
// Settings are written through cfg_write, cfg_index and cfg_data with no
// wait; write them only while no word is in flight.
// Reset clears all settings to zero, empties the queue and drops any word in
// flight.
module ipv4_loopback_remap_core #(
	parameter int TABLE_ENTRIES = ilr_pkg::TABLE_ENTRIES_DEF,
	parameter int QUEUE_DEPTH   = ilr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ilr_pkg::CMD_W-1:0]        command,
	input  logic [ilr_pkg::ADDR_W-1:0]       address,
	output logic                             done,
	output logic [ilr_pkg::STATUS_W-1:0]     status,
	output logic [ilr_pkg::ADDR_W-1:0]       result_address,
	input  logic                             cfg_write,
	input  logic [ilr_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [ilr_pkg::CFG_W-1:0]        cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ilr_pkg::cfg_t              cfg_q;
	logic [ilr_pkg::ADDR_W-1:0] offset_q   [TABLE_ENTRIES];
	logic [ilr_pkg::ADDR_W-1:0] loopback_q [TABLE_ENTRIES];
	logic                       accept;
	logic                       valid_s1;
	ilr_pkg::item_t             item_s1;
	ilr_pkg::item_t             head;
	logic                       empty;
	logic                       pop;
	logic [CNT_W-1:0]           count;

	// hold off new words when the queued words plus the one in the front end fill the queue
	assign busy   = ({1'b0, count} + (CNT_W + 1)'(valid_s1)) >= (CNT_W + 1)'(QUEUE_DEPTH);
	assign accept = start && !busy;

	// settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				offset_q[k]   <= '0;
				loopback_q[k] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				ilr_pkg::REG_IFACE_ADDRESS: cfg_q.iface_address <= cfg_data[31:0];
				ilr_pkg::REG_IFACE_MASK:    cfg_q.iface_mask    <= cfg_data[31:0];
				ilr_pkg::REG_IFACE_UP:      cfg_q.iface_up      <= cfg_data[0];
				ilr_pkg::REG_ENTRY_COUNT:   cfg_q.entry_count   <= cfg_data[2:0];
				default: begin
					for (int k = 0; k < TABLE_ENTRIES; k++) begin
						if (cfg_index == ilr_pkg::REG_IDX_W'(int'(ilr_pkg::REG_MAP_ENTRY_0) + k))
						begin
							offset_q[k]   <= cfg_data[63:32];
							loopback_q[k] <= cfg_data[31:0];
						end
					end
				end
			endcase
		end
	end

	ilr_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.command  (command),
		.address  (address),
		.cfg      (cfg_q),
		.offset   (offset_q),
		.loopback (loopback_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ilr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (item_s1),
		.pop       (pop),
		.pop_item  (head),
		.empty     (empty),
		.count     (count)
	);

	ilr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.head           (head),
		.cfg            (cfg_q),
		.pop            (pop),
		.done           (done),
		.status         (status),
		.result_address (result_address)
	);

endmodule
